>>> sv/gspc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gas sensor poll controller.
// Used by every module of the block; depends on nothing else.

package gspc_pkg;

    // Receive frame geometry and timer sizing.
    localparam int FRAME_BYTES = 11;
    localparam int TIMER_BITS  = 22;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 2);
    localparam int STORE_DEPTH = 16;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

    // Configuration register widths and reset values.
    localparam int CFG_TIMER_W = 22;
    localparam int ATTEMPT_W   = 3;
    localparam int CMP_W       = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
    localparam int ATTEMPT_CAP = 5;

    localparam logic [CFG_TIMER_W-1:0] POLL_INTERVAL_RST = CFG_TIMER_W'(60000);
    localparam logic [CFG_TIMER_W-1:0] REPLY_TIMEOUT_RST = CFG_TIMER_W'(1000);
    localparam logic [ATTEMPT_W-1:0]   MAX_ATTEMPTS_RST  = ATTEMPT_W'(3);

    // APB register map: one register every four bytes.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MAX_ATTEMPTS  = 2'd2;

    localparam logic [7:0] CHECK_BASE = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ASLEEP = 2'd1,
        ST_NORESP = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        K_TICK      = 2'd0,
        K_BYTE      = 2'd1,
        K_BYTE_LAST = 2'd2
    } kind_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic       burst_end;
        logic       awake;
    } in_item_t;

    typedef struct packed {
        logic        send_request;
        logic        push_res;
        status_t     status;
        logic [15:0] co_ppm;
        logic [15:0] h2s_ppm;
        logic [15:0] o2_vol;
        logic [15:0] ch4_lel;
    } result_t;

    // A classified item as it sits in the queue between front and back.
    typedef struct packed {
        kind_t      kind;
        logic       asleep;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [CFG_TIMER_W-1:0] poll_interval;
        logic [CFG_TIMER_W-1:0] reply_timeout;
        logic [ATTEMPT_W-1:0]   max_attempts;
    } cfg_t;

endpackage

>>> sv/gspc_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the gas sensor poll controller.
// Depends on gspc_pkg for the register map and reset values.

module gspc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gspc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gspc_pkg::DATA_W-1:0]  pwdata,
    output logic [gspc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output gspc_pkg::cfg_t               cfg
);

    gspc_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval <= gspc_pkg::POLL_INTERVAL_RST;
            cfg_reg.reply_timeout <= gspc_pkg::REPLY_TIMEOUT_RST;
            cfg_reg.max_attempts  <= gspc_pkg::MAX_ATTEMPTS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                gspc_pkg::REG_POLL_INTERVAL:
                    cfg_reg.poll_interval <= pwdata[gspc_pkg::CFG_TIMER_W-1:0];
                gspc_pkg::REG_REPLY_TIMEOUT:
                    cfg_reg.reply_timeout <= pwdata[gspc_pkg::CFG_TIMER_W-1:0];
                gspc_pkg::REG_MAX_ATTEMPTS:
                    cfg_reg.max_attempts  <= pwdata[gspc_pkg::ATTEMPT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gspc_pkg::REG_POLL_INTERVAL:
                prdata = gspc_pkg::DATA_W'(cfg_reg.poll_interval);
            gspc_pkg::REG_REPLY_TIMEOUT:
                prdata = gspc_pkg::DATA_W'(cfg_reg.reply_timeout);
            gspc_pkg::REG_MAX_ATTEMPTS:
                prdata = gspc_pkg::DATA_W'(cfg_reg.max_attempts);
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> sv/gspc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on gspc_pkg.

module gspc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  gspc_pkg::in_item_t item,
    output logic               op_valid,
    output gspc_pkg::op_t      op,
    input  logic               op_pop
);

    gspc_pkg::op_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg,  count_next;
    logic          push;
    gspc_pkg::op_t classified;

    // Ticks and bytes are told apart here, and the last byte of a burst
    // gets a kind of its own so the back end need not look at two fields.
    always_comb
    begin
        classified.asleep = !item.awake;
        classified.data   = item.rx_byte;
        priority if (!item.cmd)
            classified.kind = gspc_pkg::K_TICK;
        else if (item.burst_end)
            classified.kind = gspc_pkg::K_BYTE_LAST;
        else
            classified.kind = gspc_pkg::K_BYTE;
    end

    assign item_ready = (count_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign op_valid   = (count_reg != 2'd0);
    assign op         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = op_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(op_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

>>> sv/gspc_back.sv
`timescale 1ns / 1ps
// Back end: runs the poll, timeout and frame check logic on each queued
// beat and holds the result in an output register. Depends on gspc_pkg.

module gspc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gspc_pkg::cfg_t    cfg,
    input  logic              op_valid,
    input  gspc_pkg::op_t     op,
    output logic              op_pop,
    output logic              result_valid,
    input  logic              result_ready,
    output gspc_pkg::result_t result
);

    localparam logic [gspc_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [gspc_pkg::COUNT_W-1:0] FRAME_CNT =
        gspc_pkg::COUNT_W'(gspc_pkg::FRAME_BYTES);
    localparam logic [gspc_pkg::COUNT_W-1:0] SUM_LIMIT =
        gspc_pkg::COUNT_W'(gspc_pkg::FRAME_BYTES - 1);
    localparam logic [gspc_pkg::STORE_IDX_W-1:0] CHECK_IDX =
        gspc_pkg::STORE_IDX_W'(gspc_pkg::FRAME_BYTES - 1);
    localparam logic [gspc_pkg::ATTEMPT_W-1:0] ATTEMPT_MAX =
        gspc_pkg::ATTEMPT_W'(gspc_pkg::ATTEMPT_CAP);

    logic                              waiting_reg,     waiting_next;
    logic [gspc_pkg::TIMER_BITS-1:0]   elapsed_reg,     elapsed_next;
    logic [gspc_pkg::ATTEMPT_W-1:0]    attempts_reg,    attempts_next;
    logic [gspc_pkg::COUNT_W-1:0]      burst_count_reg, burst_count_next;
    logic [7:0]                        byte_sum_reg,    byte_sum_next;
    gspc_pkg::status_t                 status_reg,      status_next;
    logic [15:0]                       readings_reg [4];
    logic [15:0]                       readings_next [4];
    logic [7:0]                        store_reg [gspc_pkg::STORE_DEPTH];
    logic [7:0]                        frame_view [gspc_pkg::STORE_DEPTH];
    logic                              result_valid_reg, result_valid_next;
    gspc_pkg::result_t                 result_reg,       result_next;

    logic                              is_tick;
    logic                              is_byte;
    logic                              store_wr;
    logic [gspc_pkg::STORE_IDX_W-1:0]  store_idx;
    logic                              send;
    logic                              push;
    logic                              frame_ok;
    logic [7:0]                        check_byte;

    assign op_pop       = op_valid && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign is_tick   = (op.kind == gspc_pkg::K_TICK);
    assign is_byte   = !is_tick;
    assign store_idx = burst_count_reg[gspc_pkg::STORE_IDX_W-1:0];
    assign store_wr  = op_pop && !op.asleep && waiting_reg && is_byte &&
                       (burst_count_reg < FRAME_CNT);

    // The frame as it stands after this beat, so the closing byte can
    // be checked and latched in the same cycle that it arrives.
    always_comb
    begin
        for (int i = 0; i < gspc_pkg::STORE_DEPTH; i++)
        begin
            frame_view[i] = (store_wr && store_idx == gspc_pkg::STORE_IDX_W'(i)) ?
                            op.data : store_reg[i];
        end
    end

    always_comb
    begin
        elapsed_next     = elapsed_reg;
        waiting_next     = waiting_reg;
        attempts_next    = attempts_reg;
        burst_count_next = burst_count_reg;
        byte_sum_next    = byte_sum_reg;
        status_next      = status_reg;
        for (int k = 0; k < 4; k++)
        begin
            readings_next[k] = readings_reg[k];
        end
        send       = 1'b0;
        push       = 1'b0;
        frame_ok   = 1'b0;
        check_byte = 8'h00;

        if (is_tick && elapsed_reg != TIMER_MAX)
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end

        if (op.asleep)
        begin
            if (status_reg != gspc_pkg::ST_ASLEEP)
            begin
                status_next   = gspc_pkg::ST_ASLEEP;
                push          = 1'b1;
                waiting_next  = 1'b0;
                attempts_next = '0;
            end
            burst_count_next = '0;
            byte_sum_next    = '0;
        end
        else
        begin
            if (status_reg == gspc_pkg::ST_ASLEEP)
            begin
                status_next = gspc_pkg::ST_OK;
                push        = 1'b1;
            end
            if (!waiting_reg)
            begin
                if (is_tick && gspc_pkg::CMP_W'(elapsed_next) >=
                               gspc_pkg::CMP_W'(cfg.poll_interval))
                begin
                    send             = 1'b1;
                    elapsed_next     = '0;
                    waiting_next     = 1'b1;
                    burst_count_next = '0;
                    byte_sum_next    = '0;
                end
            end
            else if (is_byte)
            begin
                if (burst_count_reg < SUM_LIMIT)
                begin
                    byte_sum_next = byte_sum_reg + op.data;
                end
                if (burst_count_reg <= FRAME_CNT)
                begin
                    burst_count_next = burst_count_reg + 1'b1;
                end
                if (op.kind == gspc_pkg::K_BYTE_LAST)
                begin
                    check_byte = gspc_pkg::CHECK_BASE - byte_sum_next;
                    frame_ok   = (burst_count_next == FRAME_CNT) &&
                                 (check_byte == frame_view[CHECK_IDX]);
                    if (frame_ok)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            readings_next[k] = {frame_view[2 + 2 * k],
                                                frame_view[3 + 2 * k]};
                        end
                        attempts_next = '0;
                        elapsed_next  = '0;
                        waiting_next  = 1'b0;
                        status_next   = gspc_pkg::ST_OK;
                        push          = 1'b1;
                    end
                    burst_count_next = '0;
                    byte_sum_next    = '0;
                end
            end
            else if (gspc_pkg::CMP_W'(elapsed_next) >= gspc_pkg::CMP_W'(cfg.reply_timeout))
            begin
                if (attempts_reg < ATTEMPT_MAX)
                begin
                    attempts_next = attempts_reg + 1'b1;
                end
                burst_count_next = '0;
                byte_sum_next    = '0;
                if (attempts_next < cfg.max_attempts)
                begin
                    send = 1'b1;
                end
                else
                begin
                    if (status_reg != gspc_pkg::ST_NORESP)
                    begin
                        status_next = gspc_pkg::ST_NORESP;
                        push        = 1'b1;
                    end
                    waiting_next  = 1'b0;
                    attempts_next = '0;
                end
                elapsed_next = '0;
            end
        end

        result_next.send_request = send;
        result_next.push_res     = push;
        result_next.status       = status_next;
        result_next.co_ppm       = readings_next[0];
        result_next.h2s_ppm      = readings_next[1];
        result_next.o2_vol       = readings_next[2];
        result_next.ch4_lel      = readings_next[3];
    end

    always_comb
    begin
        priority if (op_pop)
            result_valid_next = send || push;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg      <= 1'b0;
            elapsed_reg      <= '0;
            attempts_reg     <= '0;
            burst_count_reg  <= '0;
            byte_sum_reg     <= '0;
            status_reg       <= gspc_pkg::ST_OK;
            for (int k = 0; k < 4; k++)
            begin
                readings_reg[k] <= '0;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (op_pop)
            begin
                waiting_reg     <= waiting_next;
                elapsed_reg     <= elapsed_next;
                attempts_reg    <= attempts_next;
                burst_count_reg <= burst_count_next;
                byte_sum_reg    <= byte_sum_next;
                status_reg      <= status_next;
                for (int k = 0; k < 4; k++)
                begin
                    readings_reg[k] <= readings_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            result_reg <= result_next;
        end
        if (store_wr)
        begin
            store_reg[store_idx] <= op.data;
        end
    end

endmodule

>>> sv/gas_sensor_poll_controller.sv
`timescale 1ns / 1ps
// Gas sensor poll controller. A taken input beat is registered in the front queue,
// and the result beat it causes is offered from the output register.
// Throughput: one beat per cycle, set by the back-end update, which pops only
// while the output register is empty or being taken; the two-entry queue and
// the output register let either side stall alone.
// Reset: rst_n clears all control state and readings at once and loads the
// registers with 60000, 1000 and 3; no clearing pass is needed.

module gas_sensor_poll_controller (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  gspc_pkg::in_item_t           item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output gspc_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gspc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gspc_pkg::DATA_W-1:0]  pwdata,
    output logic [gspc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    gspc_pkg::cfg_t cfg;
    logic           op_valid;
    gspc_pkg::op_t  op;
    logic           op_pop;

    gspc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gspc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .op_valid   (op_valid),
        .op         (op),
        .op_pop     (op_pop)
    );

    gspc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .op_valid     (op_valid),
        .op           (op),
        .op_pop       (op_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A result beat always carries a request or a report.
    a_result_has_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.send_request || result.push_res)
    ) else $error("result beat with neither send_request nor push_res");

    // The back end only takes from the queue when it holds something.
    a_pop_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        op_pop |-> op_valid
    ) else $error("back end popped an empty queue");

    // A sleeping sensor is never polled.
    a_no_send_asleep: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == gspc_pkg::ST_ASLEEP) |-> !result.send_request
    ) else $error("request sent while status is asleep");

endmodule

>>> tb/sv/gspc_report_checker.sv
`timescale 1ns / 1ps
// Report checker for the gas sensor poll controller testbench: predicts every report
// from the accepted item beats and register writes, and compares the result beats.
// Depends on gspc_pkg for the payload types, widths and register addresses.

module gspc_report_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  gspc_pkg::in_item_t           item,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  gspc_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gspc_pkg::ADDR_W-1:0]  paddr,
    input  logic [gspc_pkg::DATA_W-1:0]  pwdata,
    input  logic [gspc_pkg::DATA_W-1:0]  prdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           outstanding
);
    import gspc_pkg::*;

    // Register copies.
    logic [CFG_TIMER_W-1:0] poll_iv;
    logic [CFG_TIMER_W-1:0] reply_to;
    logic [ATTEMPT_W-1:0]   max_tries;

    // Poller state.
    bit                     waiting;
    logic [TIMER_BITS-1:0]  elapsed;
    logic [2:0]             tries;
    logic [4:0]             nbytes;
    logic [7:0]             sum;
    logic [7:0]             frame [STORE_DEPTH];
    status_t                stat;
    logic [15:0]            gas [4];

    result_t expected_reports [$];
    int      fails = 0;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // Applies one item beat to the poller state and queues the report it causes.
    task automatic advance_poller(input in_item_t it);
        bit         send;
        bit         push;
        logic [7:0] check;
        result_t    r;
        send = 0;
        push = 0;
        if (!it.cmd && elapsed != '1)
            elapsed++;
        if (!it.awake) begin
            if (stat != ST_ASLEEP) begin
                stat    = ST_ASLEEP;
                push    = 1;
                waiting = 0;
                tries   = 0;
            end
            nbytes = 0;
            sum    = 0;
        end else begin
            if (stat == ST_ASLEEP) begin
                stat = ST_OK;
                push = 1;
            end
            if (!waiting) begin
                if (!it.cmd && elapsed >= poll_iv) begin
                    send    = 1;
                    elapsed = 0;
                    waiting = 1;
                    nbytes  = 0;
                    sum     = 0;
                end
            end else if (it.cmd) begin
                // Bytes past the frame length are dropped and the count saturates.
                if (nbytes < FRAME_BYTES) begin
                    frame[nbytes[STORE_IDX_W-1:0]] = it.rx_byte;
                    if (nbytes < FRAME_BYTES - 1)
                        sum = sum + it.rx_byte;
                end
                if (nbytes <= FRAME_BYTES)
                    nbytes++;
                if (it.burst_end) begin
                    check = CHECK_BASE - sum;
                    if (nbytes == FRAME_BYTES && check == frame[FRAME_BYTES-1]) begin
                        for (int k = 0; k < 4; k++)
                            gas[k] = {frame[2+2*k], frame[3+2*k]};
                        tries   = 0;
                        elapsed = 0;
                        waiting = 0;
                        stat    = ST_OK;
                        push    = 1;
                    end
                    nbytes = 0;
                    sum    = 0;
                end
            end else if (elapsed >= reply_to) begin
                if (tries < ATTEMPT_CAP)
                    tries++;
                nbytes = 0;
                sum    = 0;
                if (tries < max_tries) begin
                    send = 1;
                end else begin
                    if (stat != ST_NORESP) begin
                        stat = ST_NORESP;
                        push = 1;
                    end
                    waiting = 0;
                    tries   = 0;
                end
                elapsed = 0;
            end
        end
        if (send || push) begin
            r.send_request = send;
            r.push_res     = push;
            r.status       = stat;
            r.co_ppm       = gas[0];
            r.h2s_ppm      = gas[1];
            r.o2_vol       = gas[2];
            r.ch4_lel      = gas[3];
            expected_reports.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t           want;
        logic [DATA_W-1:0] reg_now;
        bit                mapped;
        if (!rst_n) begin
            poll_iv   = POLL_INTERVAL_RST;
            reply_to  = REPLY_TIMEOUT_RST;
            max_tries = MAX_ATTEMPTS_RST;
            waiting   = 0;
            elapsed   = '0;
            tries     = '0;
            nbytes    = '0;
            sum       = '0;
            stat      = ST_OK;
            for (int i = 0; i < STORE_DEPTH; i++)
                frame[i] = '0;
            for (int i = 0; i < 4; i++)
                gas[i] = '0;
            expected_reports.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr)
                        {REG_POLL_INTERVAL, 2'b00}: poll_iv   = pwdata[CFG_TIMER_W-1:0];
                        {REG_REPLY_TIMEOUT, 2'b00}: reply_to  = pwdata[CFG_TIMER_W-1:0];
                        {REG_MAX_ATTEMPTS, 2'b00}:  max_tries = pwdata[ATTEMPT_W-1:0];
                        default: ;
                    endcase
                end else begin
                    mapped = 1;
                    reg_now = '0;
                    case (paddr)
                        {REG_POLL_INTERVAL, 2'b00}: reg_now = DATA_W'(poll_iv);
                        {REG_REPLY_TIMEOUT, 2'b00}: reg_now = DATA_W'(reply_to);
                        {REG_MAX_ATTEMPTS, 2'b00}:  reg_now = DATA_W'(max_tries);
                        default: mapped = 0;
                    endcase
                    if (mapped)
                        check_field("prdata", reg_now, prdata);
                end
            end
            if (result_valid && result_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat with no report predicted");
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("send_request", want.send_request, result.send_request);
                    check_field("push_res", want.push_res, result.push_res);
                    check_field("status", want.status, result.status);
                    check_field("co_ppm", want.co_ppm, result.co_ppm);
                    check_field("h2s_ppm", want.h2s_ppm, result.h2s_ppm);
                    check_field("o2_vol", want.o2_vol, result.o2_vol);
                    check_field("ch4_lel", want.ch4_lel, result.ch4_lel);
                end
            end
            if (item_valid && item_ready)
                advance_poller(item);
        end
        outstanding <= expected_reports.size();
        mismatches  <= fails;
    end

endmodule

>>> tb/sv/tb_gas_sensor_poll_controller.sv
`timescale 1ns / 1ps
// Testbench top for the gas sensor poll controller: clock, reset, stimulus and verdict.
// Depends on gspc_pkg, gas_sensor_poll_controller and gspc_report_checker.

module tb_gas_sensor_poll_controller;
    import gspc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 7;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              item_valid = 0;
    logic              item_ready;
    in_item_t          item = '0;
    logic              result_valid;
    logic              result_ready = 0;
    result_t           result;
    logic              psel = 0;
    logic              penable = 0;
    logic              pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    bit         gaps_on = 0;
    bit         vary_idle = 0;
    bit         throttle = 0;
    int         stall_left = 0;
    int         cycles = 0;
    int         tick_span = 4;
    logic [7:0] reply [16];

    // Register settings and length of each random phase.
    int p_list [NUM_PHASES]      = '{3, 1, -1, 2, 0, 2, 1};
    int r_list [NUM_PHASES]      = '{4, 1, 4194303, 3, 0, 2, 2};
    int m_list [NUM_PHASES]      = '{3, 1, 5, 5, 0, 7, 6};
    int span_list [NUM_PHASES]   = '{6, 3, 3, 5, 2, 4, 4};
    int rounds_list [NUM_PHASES] = '{40, 40, 10, 40, 40, 40, 40};

    gas_sensor_poll_controller u_top (.*);

    gspc_report_checker u_checker (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: while throttling, result_ready drops in stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 0;
        end
        else if (throttle && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            result_ready <= 0;
        end
        else
        begin
            result_ready <= 1;
        end
    end

    // Leaves valid high after the beat; whoever stops sending lowers it.
    task automatic put_item(input logic c, input logic [7:0] data, input logic last,
                            input logic up);
        in_item_t it;
        if (vary_idle && $urandom_range(0, 49) == 0)
            gaps_on = !gaps_on;
        if (vary_idle && $urandom_range(0, 49) == 0)
            throttle <= !throttle;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        it.cmd       = c;
        it.rx_byte   = data;
        it.burst_end = last;
        it.awake     = up;
        item       <= it;
        item_valid <= 1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic ticks(input int n);
        repeat (n)
            put_item(1'b0, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic seal_reply();
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            s = s + reply[i];
        reply[FRAME_BYTES-1] = CHECK_BASE - s;
    endtask

    // Sends reply[0..len-1] as one burst; the byte at sleep_at goes out with awake low.
    task automatic send_burst(input int len, input int sleep_at);
        for (int i = 0; i < len; i++)
            put_item(1'b1, reply[i], i == len - 1, i != sleep_at);
    endtask

    task automatic settle();
        item_valid <= 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // Read the register straight back; the checker compares prdata.
        penable <= 0;
        pwrite  <= 0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 0;
        penable <= 0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] r,
                             input logic [DATA_W-1:0] m);
        settle();
        write_reg(REG_POLL_INTERVAL, p);
        write_reg(REG_REPLY_TIMEOUT, r);
        write_reg(REG_MAX_ATTEMPTS, m);
    endtask

    task automatic random_round();
        int pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 16; i++)
            reply[i] = 8'($urandom);
        seal_reply();
        if (pick < 40)
        begin
            ticks($urandom_range(1, tick_span));
        end
        else if (pick < 75)
        begin
            send_burst(FRAME_BYTES, -1);
        end
        else if (pick < 80)
        begin
            // A single flipped bit always breaks the checksum.
            reply[$urandom_range(0, FRAME_BYTES - 1)] ^= 8'(1 << $urandom_range(0, 7));
            send_burst(FRAME_BYTES, -1);
        end
        else if (pick < 85)
        begin
            send_burst($urandom_range(1, FRAME_BYTES - 1), -1);
        end
        else if (pick < 89)
        begin
            send_burst($urandom_range(FRAME_BYTES + 1, 16), -1);
        end
        else if (pick < 92)
        begin
            send_burst(FRAME_BYTES, $urandom_range(0, FRAME_BYTES - 1));
        end
        else if (pick < 96)
        begin
            put_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                put_item(1'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part, reset settings first: sleep, wake, bytes while idle.
        put_item(1'b0, 8'h00, 1'b0, 1'b0);
        put_item(1'b1, 8'hFF, 1'b1, 1'b1);
        put_item(1'b1, 8'h00, 1'b0, 1'b1);

        configure(1, 2, 2);
        // Request, then a good frame of extreme bytes.
        ticks(1);
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            reply[i] = i[0] ? 8'h00 : 8'hFF;
        seal_reply();
        send_burst(FRAME_BYTES, -1);
        // Request, one retry, then no response.
        ticks(5);
        // Request, a stray byte, then sleep in the middle of the wait.
        ticks(1);
        put_item(1'b1, 8'h5A, 1'b0, 1'b1);
        put_item(1'b0, 8'hA5, 1'b1, 1'b0);

        vary_idle = 1;
        gaps_on   = 1;
        throttle <= 1;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            configure(DATA_W'(p_list[ph]), DATA_W'(r_list[ph]), DATA_W'(m_list[ph]));
            tick_span = span_list[ph];
            repeat (rounds_list[ph])
                random_round();
        end

        // Last stretch runs at full rate on both sides.
        vary_idle = 0;
        gaps_on   = 0;
        throttle <= 0;
        configure(2, 5, 4);
        tick_span = 7;
        repeat (30)
            random_round();

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
